// ----- rtl/shadow_call_stack_tracker_top_macros.svh -----
// Assertion macros shared by the shadow call stack tracker RTL.
`ifndef SHADOW_CALL_STACK_TRACKER_TOP_MACROS_SVH
`define SHADOW_CALL_STACK_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/scst_pkg.sv -----
// Types, constants and state codes for the shadow call stack tracker.
package scst_pkg;

    localparam int MAX_FRAMES = 511;
    localparam int ADDR_WIDTH = 32;

    localparam int SLOT_W  = $clog2(MAX_FRAMES);
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int IDX_W   = 9;
    localparam int DEPTH_W = 9;
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [1:0] OP_CALL  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [31:0]      src_addr;
        logic [31:0]      dest_addr;
        logic [31:0]      return_addr;
        logic [31:0]      stack_pointer;
        logic [7:0]       frame_flags;
        logic [IDX_W-1:0] frame_index;
    } cmd_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               stack_empty;
        logic [31:0]        top_return_addr;
        logic [31:0]        top_return_sp;
        logic               read_valid;
        logic [31:0]        read_source;
        logic [31:0]        read_target;
        logic [31:0]        read_return;
        logic [31:0]        read_sp;
        logic [7:0]         read_flags;
    } res_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] ret;
        logic [31:0] sp;
        logic [7:0]  flags;
    } frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_POP_RD,
        ST_POP_CHK,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_SUB_WR
    } state_t;

endpackage

// ----- rtl/scst_frame_ram.sv -----
// Single-port frame memory with a registered read port.
module scst_frame_ram
    import scst_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [SLOT_W-1:0] addr,
    input  frame_t            wdata,
    output frame_t            rdata
);

    frame_t mem [MAX_FRAMES];
    frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/shadow_call_stack_tracker_top.sv -----
// Top level of the shadow call stack tracker: sequencer, slot unit and frame memory.
//
// A transaction is accepted at a rising edge where start is high and busy is low;
// the command fields travel on cmd. Exactly one result comes back per transaction:
// result is valid for one cycle while done is high, and the receiver cannot stall it.
// Frames live in a ring held in one single-port memory; a single slot adder with a
// compare and subtract maps a frame position to its ring slot, one access per cycle.
// Every command is taken up in the execute state. Call, clear, a read beyond the depth
// and a return that empties the stack or finds no frames finish there; a read of a
// held frame finishes in the read-wait state. A return whose destination matches the
// top frame fetches the new top through the top-read and top-wait states. A return
// that searches reads and checks the frames below the popped one in turn, then fetches
// the new top after a match that leaves frames, or pushes a substitute frame when none
// matches and the stack pointer differs. The busy output stays high until done is
// raised, so one transaction is in flight at a time and done and the next accept may
// coincide.
// Reset empties the stack and clears the ring origin at once; the memory is not
// swept, since only frames below the depth are ever read.
`include "shadow_call_stack_tracker_top_macros.svh"

module shadow_call_stack_tracker_top
    import scst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output res_t result
);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [31:0]       top_ret_reg, top_ret_next;
    logic [31:0]       top_sp_reg, top_sp_next;
    logic [31:0]       prev_ret_reg, prev_ret_next;
    logic [31:0]       ntop_ret_reg, ntop_ret_next;
    logic [31:0]       ntop_sp_reg, ntop_sp_next;
    res_t              res_reg, res_next;
    logic              done_reg, done_next;

    logic              mem_en;
    logic              mem_we;
    frame_t            mem_wdata;
    frame_t            mem_rdata;

    logic [CNT_W-1:0]  slot_off;
    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] oldest_inc;
    logic [31:0]       dest_m;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  idx_dec;
    logic              hit;
    logic              first;
    logic [31:0]       cand_ret;
    logic [31:0]       cand_sp;
    logic              idx_lt;
    logic              count_full;
    logic              finish;

    logic              accept;
    logic              walk_rd;
    logic              walk_ok;
    logic              empty_ok;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    assign dest_m     = cmd_reg.dest_addr & ADDR_MASK;
    assign count_dec  = count_reg - CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign hit        = (mem_rdata.ret == dest_m);
    assign first      = (idx_reg == count_reg);
    assign cand_ret   = first ? mem_rdata.ret : ntop_ret_reg;
    assign cand_sp    = first ? mem_rdata.sp : ntop_sp_reg;
    assign idx_lt     = (CMP_W'(cmd_reg.frame_index) < CMP_W'(count_reg));
    assign count_full = (count_reg == CNT_W'(MAX_FRAMES));
    assign oldest_inc = (oldest_reg == SLOT_W'(MAX_FRAMES - 1)) ? '0
                        : oldest_reg + SLOT_W'(1);

    // Shared slot unit: ring position of the frame at a given offset from the oldest.
    always_comb
    begin
        case (state_reg)
            ST_EXEC:
            begin
                if (cmd_reg.opcode == OP_READ)
                begin
                    slot_off = CNT_W'(cmd_reg.frame_index);
                end
                else
                begin
                    slot_off = count_reg;
                end
            end
            ST_POP_RD:    slot_off = idx_dec;
            ST_TOP_RD:    slot_off = idx_dec;
            ST_SUB_WR:    slot_off = count_reg;
            default:      slot_off = '0;
        endcase
    end

    assign slot_sum = SUM_W'(oldest_reg) + SUM_W'(slot_off);
    assign slot     = (slot_sum >= SUM_W'(MAX_FRAMES)) ? SLOT_W'(slot_sum - SUM_W'(MAX_FRAMES))
                      : SLOT_W'(slot_sum);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg.opcode)
                    OP_READ:
                    begin
                        state_next = idx_lt ? ST_READ_WAIT : ST_IDLE;
                    end
                    OP_POP:
                    begin
                        if (count_reg <= CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (dest_m == top_ret_reg)
                        begin
                            state_next = ST_TOP_RD;
                        end
                        else
                        begin
                            state_next = ST_POP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_CHK;
            end
            ST_POP_CHK:
            begin
                if (hit)
                begin
                    state_next = (idx_reg == CNT_W'(1)) ? ST_IDLE : ST_TOP_RD;
                end
                else if (idx_reg > CNT_W'(1))
                begin
                    state_next = ST_POP_RD;
                end
                else if (cand_sp != cmd_reg.stack_pointer)
                begin
                    state_next = ST_SUB_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOP_RD:
            begin
                state_next = ST_TOP_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        oldest_next   = oldest_reg;
        idx_next      = idx_reg;
        top_ret_next  = top_ret_reg;
        top_sp_next   = top_sp_reg;
        prev_ret_next = prev_ret_reg;
        ntop_ret_next = ntop_ret_reg;
        ntop_sp_next  = ntop_sp_reg;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = '0;
        finish        = 1'b0;
        res_next      = res_reg;
        done_next     = 1'b0;

        case (state_reg)
            ST_EXEC:
            begin
                case (cmd_reg.opcode)
                    OP_CALL:
                    begin
                        mem_en          = 1'b1;
                        mem_we          = 1'b1;
                        mem_wdata.src   = cmd_reg.src_addr & ADDR_MASK;
                        mem_wdata.tgt   = dest_m;
                        mem_wdata.ret   = cmd_reg.return_addr & ADDR_MASK;
                        mem_wdata.sp    = cmd_reg.stack_pointer;
                        mem_wdata.flags = cmd_reg.frame_flags;
                        if (count_full)
                        begin
                            oldest_next = oldest_inc;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        top_ret_next = cmd_reg.return_addr & ADDR_MASK;
                        top_sp_next  = cmd_reg.stack_pointer;
                        finish       = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        finish     = 1'b1;
                    end
                    OP_READ:
                    begin
                        if (idx_lt)
                        begin
                            mem_en = 1'b1;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (count_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            count_next    = count_dec;
                            idx_next      = count_dec;
                            prev_ret_next = top_ret_reg;
                            finish        = (count_reg == CNT_W'(1));
                        end
                    end
                endcase
            end
            ST_POP_RD:
            begin
                mem_en = 1'b1;
            end
            ST_POP_CHK:
            begin
                if (first)
                begin
                    ntop_ret_next = mem_rdata.ret;
                    ntop_sp_next  = mem_rdata.sp;
                end
                if (hit)
                begin
                    count_next = idx_dec;
                    idx_next   = idx_dec;
                    finish     = (idx_reg == CNT_W'(1));
                end
                else if (idx_reg > CNT_W'(1))
                begin
                    idx_next = idx_dec;
                end
                else if (cand_sp == cmd_reg.stack_pointer)
                begin
                    top_ret_next = cand_ret;
                    top_sp_next  = cand_sp;
                    finish       = 1'b1;
                end
            end
            ST_TOP_RD:
            begin
                mem_en = 1'b1;
            end
            ST_TOP_WAIT:
            begin
                top_ret_next = mem_rdata.ret;
                top_sp_next  = mem_rdata.sp;
                finish       = 1'b1;
            end
            ST_SUB_WR:
            begin
                mem_en          = 1'b1;
                mem_we          = 1'b1;
                mem_wdata.src   = prev_ret_reg;
                mem_wdata.tgt   = dest_m;
                mem_wdata.ret   = prev_ret_reg;
                mem_wdata.sp    = cmd_reg.stack_pointer;
                mem_wdata.flags = '0;
                count_next      = count_reg + CNT_W'(1);
                top_ret_next    = prev_ret_reg;
                top_sp_next     = cmd_reg.stack_pointer;
                finish          = 1'b1;
            end
            ST_READ_WAIT:
            begin
                finish = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            done_next                = 1'b1;
            res_next                 = '0;
            res_next.depth           = DEPTH_W'(count_next);
            res_next.stack_empty     = (count_next == '0);
            if (count_next != '0)
            begin
                res_next.top_return_addr = top_ret_next;
                res_next.top_return_sp   = top_sp_next;
            end
            if (state_reg == ST_READ_WAIT)
            begin
                res_next.read_valid  = 1'b1;
                res_next.read_source = mem_rdata.src;
                res_next.read_target = mem_rdata.tgt;
                res_next.read_return = mem_rdata.ret;
                res_next.read_sp     = mem_rdata.sp;
                res_next.read_flags  = mem_rdata.flags;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            oldest_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        idx_reg      <= idx_next;
        top_ret_reg  <= top_ret_next;
        top_sp_reg   <= top_sp_next;
        prev_ret_reg <= prev_ret_next;
        ntop_ret_reg <= ntop_ret_next;
        ntop_sp_reg  <= ntop_sp_next;
        res_reg      <= res_next;
    end

    scst_frame_ram u_frame_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (slot),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign accept   = start && !busy;
    assign walk_rd  = (state_reg == ST_POP_RD) || (state_reg == ST_TOP_RD);
    assign walk_ok  = (idx_reg != '0) && (idx_reg <= count_reg);
    assign empty_ok = !res_reg.stack_empty
                      || ((res_reg.depth == '0) && (res_reg.top_return_addr == '0));

    `SCST_ASSERT_NOW(a_done_when_idle, done_reg, state_reg == ST_IDLE, "Result strobe while busy.")
    `SCST_ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_EXEC, "Transaction did not start.")
    `SCST_ASSERT_NOW(a_origin_in_ring, 1'b1, oldest_reg < SLOT_W'(MAX_FRAMES), "Bad ring origin.")
    `SCST_ASSERT_NOW(a_search_in_stack, walk_rd, walk_ok, "Stack walk outside the frames.")
    `SCST_ASSERT_NOW(a_empty_result, done_reg, empty_ok, "Empty stack reported with a frame.")

endmodule
